// File: rtl/vrt_pkg.sv
// Shared constants and types for the voxel ray traversal block.
`default_nettype none
package vrt_pkg;

   localparam int COORD_BITS    = 16;
   localparam int MAX_RESULTS   = 64;
   localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);
   localparam int CMP_BITS      = (COORD_BITS > CNT_BITS) ? COORD_BITS : CNT_BITS;
   localparam int ACC_BITS      = COORD_BITS + CNT_BITS;
   localparam int MAXP_BITS     = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [MAXP_BITS-1:0] MAXP_RESET = MAXP_BITS'(64);

   typedef enum logic [0:0] {
      REG_MAX_POINTS = 1'b0
   } reg_index_type;

   // Classified ray as handed from the front end to the stepper.
   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] start;
      logic [2:0][COORD_BITS-1:0] span;
      logic [2:0]                 neg;
   } ray_type;

endpackage
`default_nettype wire

// File: rtl/vrt_if.sv
// Ray request and voxel response channel interfaces.
`default_nettype none
interface vrt_req_if;
   import vrt_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] start_z;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic signed [COORD_BITS-1:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   output ready);
endinterface

interface vrt_rsp_if;
   import vrt_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] voxel_x;
   logic signed [COORD_BITS-1:0] voxel_y;
   logic signed [COORD_BITS-1:0] voxel_z;
   logic                         last;
   logic                         reached_end;

   modport source (output valid, voxel_x, voxel_y, voxel_z, last, reached_end,
                   input ready);
   modport sink   (input valid, voxel_x, voxel_y, voxel_z, last, reached_end,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/voxel_ray_traversal_3d.sv
// Top level of the 3D voxel ray traversal block.
// A ray beat carries integer start and end voxels; the block emits the start
// voxel and then one voxel per axis step until the end voxel or the point limit
// (max_points, clamped to 1..64) is reached, flagging the final beat with last
// and, if the end was reached, reached_end. A ray with start equal to end is
// taken and emits nothing. The stepper produces one voxel per cycle when the
// response side is ready, and loads each ray from the two-entry ray queue
// before it steps it; the front end keeps taking rays while the queue has
// room. Axis choice uses running cross products, so no multiplier sits in
// the step loop.
`default_nettype none
module voxel_ray_traversal_3d (
   input  logic                              clock,
   input  logic                              reset,
   vrt_req_if.sink                           req_beat,
   vrt_rsp_if.source                         rsp_beat,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vrt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [vrt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [vrt_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import vrt_pkg::*;

   logic [MAXP_BITS-1:0] max_points_ff, max_points_in;
   logic                 csr_hit;
   logic                 q_full, q_push, q_pop, q_valid;
   ray_type              front_ray, queue_ray;

   assign csr_hit    = (reg_index_type'(csr_paddr[2]) == REG_MAX_POINTS);
   assign csr_pready = 1'b1;

   always_comb begin
      max_points_in = max_points_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         max_points_in = csr_pwdata[MAXP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_points_ff <= MAXP_RESET;
      end else begin
         max_points_ff <= max_points_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(max_points_ff) : '0;

   vrt_front u_front (
      .req  (req_beat),
      .full (q_full),
      .push (q_push),
      .ray  (front_ray)
   );

   vrt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .ray_in  (front_ray),
      .full    (q_full),
      .pop     (q_pop),
      .q_valid (q_valid),
      .ray_out (queue_ray)
   );

   vrt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .max_points (max_points_ff),
      .q_valid    (q_valid),
      .ray        (queue_ray),
      .pop        (q_pop),
      .rsp        (rsp_beat)
   );

endmodule
`default_nettype wire

// File: rtl/vrt_front.sv
// Front end: accepts ray beats, computes per-axis span and direction, drops null rays.
`default_nettype none
module vrt_front (
   vrt_req_if.sink          req,
   input  logic             full,
   output logic             push,
   output vrt_pkg::ray_type ray
);
   import vrt_pkg::*;

   logic [2:0][COORD_BITS-1:0] start_c;
   logic [2:0][COORD_BITS-1:0] end_c;
   logic                       null_ray;

   assign start_c = {req.start_z, req.start_y, req.start_x};
   assign end_c   = {req.end_z, req.end_y, req.end_x};

   always_comb begin
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] mag;
      ray.start = start_c;
      ray.span  = '0;
      ray.neg   = '0;
      for (int a = 0; a < 3; a++) begin
         d = {end_c[a][COORD_BITS-1], end_c[a]} - {start_c[a][COORD_BITS-1], start_c[a]};
         mag = d[COORD_BITS] ? (~d + 1'b1) : d;
         ray.neg[a]  = d[COORD_BITS];
         ray.span[a] = mag[COORD_BITS-1:0];
      end
   end

   // start == end on all axes emits nothing: take the beat and drop it
   assign null_ray  = (ray.span == '0);
   assign req.ready = !full;
   assign push      = req.valid && !full && !null_ray;

endmodule
`default_nettype wire

// File: rtl/vrt_queue.sv
// Two-entry ray queue between front end and stepper.
`default_nettype none
module vrt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vrt_pkg::ray_type ray_in,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output vrt_pkg::ray_type ray_out
);
   import vrt_pkg::*;

   ray_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign ray_out = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= ray_in;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/vrt_back.sv
// Stepper: walks one voxel per cycle, when the response side is ready, using incremental cross products.
`default_nettype none
module vrt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vrt_pkg::MAXP_BITS-1:0] max_points,
   input  logic                          q_valid,
   input  vrt_pkg::ray_type              ray,
   output logic                          pop,
   vrt_rsp_if.source                     rsp
);
   import vrt_pkg::*;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   logic                       busy_ff, busy_in;
   logic [2:0][COORD_BITS-1:0] pos_ff, pos_in;
   logic [2:0][COORD_BITS-1:0] span_ff, span_in;
   logic [2:0]                 neg_ff, neg_in;
   logic [2:0][CNT_BITS-1:0]   k_ff, k_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   // p_ab = k_a * span_b, kept as running sums
   logic [ACC_BITS-1:0]        pxy_ff, pxy_in, pxz_ff, pxz_in;
   logic [ACC_BITS-1:0]        pyx_ff, pyx_in, pyz_ff, pyz_in;
   logic [ACC_BITS-1:0]        pzx_ff, pzx_in, pzy_ff, pzy_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0][COORD_BITS-1:0] vox_ff, vox_in;
   logic                       last_ff, last_in;
   logic                       reached_ff, reached_in;

   logic [CNT_BITS-1:0]        lim;
   logic [CNT_BITS-1:0]        cnt_next;
   logic [2:0]                 k_done;
   logic                       at_end, stop, advance;
   logic                       tl_xy, tl_xz, tl_yz;
   axis_type                   ax;

   function automatic logic t_less(input logic [COORD_BITS-1:0] da,
                                   input logic [COORD_BITS-1:0] db,
                                   input logic [ACC_BITS-1:0]   pab,
                                   input logic [ACC_BITS-1:0]   pba);
      logic r;
      if (da == '0) begin
         r = 1'b0;
      end else if (db == '0) begin
         r = 1'b1;
      end else begin
         r = (pab < pba);
      end
      return r;
   endfunction

   always_comb begin
      if (max_points == '0) begin
         lim = CNT_BITS'(1);
      end else if (MAXP_BITS'(max_points) > MAXP_BITS'(MAX_RESULTS)) begin
         lim = CNT_BITS'(MAX_RESULTS);
      end else begin
         lim = CNT_BITS'(max_points);
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         k_done[a] = (CMP_BITS'(k_ff[a]) == CMP_BITS'(span_ff[a]));
      end
   end

   assign at_end   = &k_done;
   assign cnt_next = cnt_ff + 1'b1;
   assign stop     = at_end || (cnt_next >= lim);
   assign advance  = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign pop      = !busy_ff && q_valid;

   assign tl_xy = t_less(span_ff[0], span_ff[1], pxy_ff, pyx_ff);
   assign tl_xz = t_less(span_ff[0], span_ff[2], pxz_ff, pzx_ff);
   assign tl_yz = t_less(span_ff[1], span_ff[2], pyz_ff, pzy_ff);

   always_comb begin
      if (tl_xy) begin
         ax = tl_xz ? AXIS_X : AXIS_Z;
      end else begin
         ax = tl_yz ? AXIS_Y : AXIS_Z;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      span_in      = span_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      pxy_in       = pxy_ff;
      pxz_in       = pxz_ff;
      pyx_in       = pyx_ff;
      pyz_in       = pyz_ff;
      pzx_in       = pzx_ff;
      pzy_in       = pzy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      vox_in       = vox_ff;
      last_in      = last_ff;
      reached_in   = reached_ff;

      if (pop) begin
         busy_in = 1'b1;
         pos_in  = ray.start;
         span_in = ray.span;
         neg_in  = ray.neg;
         k_in    = '0;
         cnt_in  = '0;
         pxy_in  = '0;
         pxz_in  = '0;
         pyx_in  = '0;
         pyz_in  = '0;
         pzx_in  = '0;
         pzy_in  = '0;
      end else if (advance) begin
         rsp_valid_in = 1'b1;
         vox_in       = pos_ff;
         last_in      = stop;
         reached_in   = stop && at_end;
         cnt_in       = cnt_next;
         if (stop) begin
            busy_in = 1'b0;
         end else begin
            unique case (ax)
               AXIS_X: begin
                  pos_in[0] = neg_ff[0] ? pos_ff[0] - 1'b1 : pos_ff[0] + 1'b1;
                  k_in[0]   = k_ff[0] + 1'b1;
                  pxy_in    = pxy_ff + ACC_BITS'(span_ff[1]);
                  pxz_in    = pxz_ff + ACC_BITS'(span_ff[2]);
               end
               AXIS_Y: begin
                  pos_in[1] = neg_ff[1] ? pos_ff[1] - 1'b1 : pos_ff[1] + 1'b1;
                  k_in[1]   = k_ff[1] + 1'b1;
                  pyx_in    = pyx_ff + ACC_BITS'(span_ff[0]);
                  pyz_in    = pyz_ff + ACC_BITS'(span_ff[2]);
               end
               AXIS_Z: begin
                  pos_in[2] = neg_ff[2] ? pos_ff[2] - 1'b1 : pos_ff[2] + 1'b1;
                  k_in[2]   = k_ff[2] + 1'b1;
                  pzx_in    = pzx_ff + ACC_BITS'(span_ff[0]);
                  pzy_in    = pzy_ff + ACC_BITS'(span_ff[1]);
               end
               default: begin
                  k_in = k_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      span_ff    <= span_in;
      neg_ff     <= neg_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      pxy_ff     <= pxy_in;
      pxz_ff     <= pxz_in;
      pyx_ff     <= pyx_in;
      pyz_ff     <= pyz_in;
      pzx_ff     <= pzx_in;
      pzy_ff     <= pzy_in;
      vox_ff     <= vox_in;
      last_ff    <= last_in;
      reached_ff <= reached_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.voxel_x     = vox_ff[0];
   assign rsp.voxel_y     = vox_ff[1];
   assign rsp.voxel_z     = vox_ff[2];
   assign rsp.last        = last_ff;
   assign rsp.reached_end = reached_ff;

`ifndef SYNTH
   a_reached_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && reached_ff |-> last_ff)
      else $error("reached_end set on a beat that is not last");
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < lim)
      else $error("emitted more voxels than the point limit");
   a_no_overshoot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CMP_BITS'(k_ff[0]) <= CMP_BITS'(span_ff[0])) &&
                  (CMP_BITS'(k_ff[1]) <= CMP_BITS'(span_ff[1])) &&
                  (CMP_BITS'(k_ff[2]) <= CMP_BITS'(span_ff[2])))
      else $error("axis stepped past its span");
   a_pop_starts_ray: assert property (@(posedge clock) disable iff (reset)
      pop |=> busy_ff && cnt_ff == '0)
      else $error("ray popped without starting a run");
`endif

endmodule
`default_nettype wire

// File: sim/vrt_checker.sv
// Checker for the voxel ray traversal block: predicts the voxel run of each ray and compares.
`timescale 1ns / 1ps
module vrt_checker (
   input  logic                              clock,
   input  logic                              reset,
   vrt_req_if                                req,
   vrt_rsp_if                                rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vrt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [vrt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [vrt_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                outstanding
);
   import vrt_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR = CSR_ADDR_BITS'(4 * REG_MAX_POINTS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic                         last;
      logic                         reached_end;
   } voxel_beat_type;

   voxel_beat_type        voxel_q[$];
   logic [MAXP_BITS-1:0]  point_limit;
   voxel_beat_type        want;

   // axis a crosses its next boundary strictly before axis b; zero span never does
   function automatic bit crosses_first(longint ka, longint da, longint kb, longint db);
      if (da == 0) return 1'b0;
      if (db == 0) return 1'b1;
      return (ka * db) < (kb * da);
   endfunction

   function automatic void trace_ray(
      input logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey, ez
   );
      longint         pos[3];
      longint         dir[3];
      longint         span[3];
      longint         taken[3];
      longint         d;
      int             cap;
      int             count;
      int             ax;
      bit             at_end;
      bit             stop;
      voxel_beat_type beat;
      pos[0] = sx;
      pos[1] = sy;
      pos[2] = sz;
      span[0] = longint'(ex) - pos[0];
      span[1] = longint'(ey) - pos[1];
      span[2] = longint'(ez) - pos[2];
      for (int a = 0; a < 3; a++) begin
         d = span[a];
         dir[a] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
         span[a] = (d < 0) ? -d : d;
         taken[a] = 0;
      end
      if (span[0] == 0 && span[1] == 0 && span[2] == 0) return;
      cap = int'(point_limit);
      if (cap == 0) cap = 1;
      if (cap > MAX_RESULTS) cap = MAX_RESULTS;
      count = 0;
      do begin
         at_end = (taken[0] == span[0]) && (taken[1] == span[1]) &&
                  (taken[2] == span[2]);
         stop = at_end || (count + 1 >= cap);
         beat.x = pos[0][COORD_BITS-1:0];
         beat.y = pos[1][COORD_BITS-1:0];
         beat.z = pos[2][COORD_BITS-1:0];
         beat.last = stop;
         beat.reached_end = stop && at_end;
         voxel_q.insert(voxel_q.size(), beat);
         count++;
         if (!stop) begin
            // ties resolve to z over x and y, and to y over x
            if (crosses_first(taken[0], span[0], taken[1], span[1]))
               ax = crosses_first(taken[0], span[0], taken[2], span[2]) ? 0 : 2;
            else
               ax = crosses_first(taken[1], span[1], taken[2], span[2]) ? 1 : 2;
            pos[ax] += dir[ax];
            taken[ax]++;
         end
      end while (!stop);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         point_limit = MAXP_RESET;
         voxel_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LIMIT_ADDR) begin
            if (csr_pwrite) begin
               point_limit = csr_pwdata[MAXP_BITS-1:0];
            end else if (csr_prdata[MAXP_BITS-1:0] !== point_limit) begin
               fail_count++;
               $display("%0t: max_points read mismatch expected %0d actual %0d",
                        $time, point_limit, csr_prdata[MAXP_BITS-1:0]);
            end
         end
         if (req.valid && req.ready)
            trace_ray(req.start_x, req.start_y, req.start_z,
                      req.end_x, req.end_y, req.end_z);
         if (rsp.valid && rsp.ready) begin
            if (voxel_q.size() == 0) begin
               fail_count++;
               $display("%0t: voxel beat with nothing expected, actual (%0d,%0d,%0d) %s",
                        $time, rsp.voxel_x, rsp.voxel_y, rsp.voxel_z,
                        $sformatf("last=%0b end=%0b", rsp.last, rsp.reached_end));
            end else begin
               want = voxel_q.pop_front();
               if (rsp.voxel_x !== want.x || rsp.voxel_y !== want.y ||
                   rsp.voxel_z !== want.z || rsp.last !== want.last ||
                   rsp.reached_end !== want.reached_end) begin
                  fail_count++;
                  $display("%0t: voxel mismatch expected (%0d,%0d,%0d) last=%0b end=%0b %s",
                           $time, want.x, want.y, want.z, want.last, want.reached_end,
                           $sformatf("actual (%0d,%0d,%0d) last=%0b end=%0b",
                                     rsp.voxel_x, rsp.voxel_y, rsp.voxel_z,
                                     rsp.last, rsp.reached_end));
               end
            end
         end
      end
      outstanding = voxel_q.size();
   end

endmodule

// File: sim/testbench.sv
// Testbench top for the voxel ray traversal block: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module testbench;
   import vrt_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR = CSR_ADDR_BITS'(4 * REG_MAX_POINTS);
   localparam int RAYS_PER_PHASE = 63;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 500;
   localparam int LIMIT_CYCLES   = 400000;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       fail_count;
   int                       outstanding;
   int                       cycle_count;
   logic                     steady;
   logic                     stall_request;
   int                       limit_steps[8] = '{1, 127, 0, 64, 7, 200, 33, 64};

   vrt_req_if req_bus ();
   vrt_rsp_if rsp_bus ();

   voxel_ray_traversal_3d DUT (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_bus),
      .rsp_beat    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   vrt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // keep an offset inside the coordinate range by mirroring it about the start
   function automatic int fold(int from, int to);
      if (to > 32767 || to < -32768) return 2 * from - to;
      return to;
   endfunction

   task automatic drive_ray(input int sx, sy, sz, ex, ey, ez);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.start_x <= COORD_BITS'(sx);
      req_bus.start_y <= COORD_BITS'(sy);
      req_bus.start_z <= COORD_BITS'(sz);
      req_bus.end_x   <= COORD_BITS'(ex);
      req_bus.end_y   <= COORD_BITS'(ey);
      req_bus.end_z   <= COORD_BITS'(ez);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic random_ray();
      int kind;
      int mag;
      int from[3];
      int to[3];
      kind = $urandom_range(0, 99);
      for (int a = 0; a < 3; a++) begin
         from[a] = int'($urandom_range(0, 65535)) - 32768;
         to[a]   = int'($urandom_range(0, 65535)) - 32768;
      end
      mag = $urandom_range(1, 30);
      for (int a = 0; a < 3; a++) begin
         if (kind < 60) begin
            // short ray, mostly reaches its end
            to[a] = ($urandom_range(0, 4) == 0) ? from[a]
                    : fold(from[a], from[a] + int'($urandom_range(0, 80)) - 40);
         end else if (kind < 75) begin
            // equal spans on the moving axes exercise the tie order
            to[a] = ($urandom_range(0, 3) == 0) ? from[a]
                    : fold(from[a], from[a] + ($urandom_range(0, 1) ? mag : -mag));
         end else if (kind < 90) begin
            to[a] = to[a];
         end else if (kind < 95) begin
            to[a] = from[a];
         end else begin
            case ($urandom_range(0, 3))
               0: from[a] = -32768;
               1: from[a] = 32767;
               2: from[a] = 0;
               default: from[a] = -1;
            endcase
            case ($urandom_range(0, 3))
               0: to[a] = -32768;
               1: to[a] = 32767;
               2: to[a] = 0;
               default: to[a] = -1;
            endcase
         end
      end
      drive_ray(from[0], from[1], from[2], to[0], to[1], to[2]);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write max_points, then read it back
   task automatic program_limit(input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      bit hold_done;
      int hold_left;
      hold_done = 1'b0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      steady          <= 1'b0;
      stall_request   <= 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.start_z <= '0;
      req_bus.end_x   <= '0;
      req_bus.end_y   <= '0;
      req_bus.end_z   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed rays at the reset point limit
      drive_ray(0, 0, 0, 0, 0, 0);
      drive_ray(-32768, -32768, -32768, -32768, -32768, -32768);
      drive_ray(0, 0, 0, 5, 0, 0);
      drive_ray(0, 0, 0, 0, -5, 0);
      drive_ray(0, 0, 0, 0, 0, 7);
      drive_ray(0, 0, 0, 3, 3, 3);
      drive_ray(0, 0, 0, 2, 2, 0);
      drive_ray(0, 0, 0, 0, 2, 2);
      drive_ray(0, 0, 0, -2, 0, -2);
      drive_ray(10, -10, 5, -3, 4, 9);
      drive_ray(32767, 32767, 32767, 32760, 32767, 32767);
      drive_ray(-32768, 0, 0, 32767, 0, 0);
      drive_ray(-32768, -32768, -32768, 32767, 32767, 32767);
      drive_ray(32767, -32768, 32767, -32768, 32767, -32768);
      drive_ray(1, 2, 3, 1, 2, 4);
      drive_ray(100, 100, 100, 163, 100, 100);
      drive_ray(100, 100, 100, 164, 100, 100);
      drive_ray(0, 0, 0, 1, -1, 1);
      drive_ray(-1, -1, -1, 0, 0, 0);
      drive_ray(0, 0, 0, 40, -17, 9);
      drive_ray(5, 5, 5, 5, 5, 5);
      drive_ray(0, 0, 0, 1, 2, 0);

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         program_limit(CSR_DATA_BITS'(limit_steps[phase]));
         steady <= (phase == 5);
         if (phase == 3) stall_request <= 1'b1;
         repeat (RAYS_PER_PHASE) random_ray();
      end
      settle();

      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
